// ===== rtl/sha1mh_pkg.sv =====
// sha1mh_pkg: constants and types of the sha-1 message hash engine
// used by sha1_message_hash_top and its port checker; no dependencies
`timescale 1ns / 1ps

package sha1mh_pkg;

    // widths of the stream fields
    localparam int ACTION_W  = 2;
    localparam int BYTE_W    = 8;
    localparam int WORD_W    = 32;
    localparam int DIGEST_W  = 5 * WORD_W;
    localparam int BLOCK_W   = 512;
    localparam int COUNT_W   = 64;
    localparam int FILL_W    = 6;
    localparam int ROUND_W   = 7;
    localparam int LAST_ROUND = 79;

    // action codes carried in tuser
    typedef enum logic [ACTION_W-1:0] {
        ACT_ABSORB     = 2'd0,
        ACT_ABSORB_END = 2'd1,
        ACT_END        = 2'd2,
        ACT_NONE       = 2'd3
    } action_t;

    // initial chaining vector
    localparam logic [WORD_W-1:0] IV0 = 32'h6745_2301;
    localparam logic [WORD_W-1:0] IV1 = 32'hEFCD_AB89;
    localparam logic [WORD_W-1:0] IV2 = 32'h98BA_DCFE;
    localparam logic [WORD_W-1:0] IV3 = 32'h1032_5476;
    localparam logic [WORD_W-1:0] IV4 = 32'hC3D2_E1F0;

    // round constants, one per group of twenty rounds
    localparam logic [WORD_W-1:0] K0 = 32'h5A82_7999;
    localparam logic [WORD_W-1:0] K1 = 32'h6ED9_EBA1;
    localparam logic [WORD_W-1:0] K2 = 32'h8F1B_BCDC;
    localparam logic [WORD_W-1:0] K3 = 32'hCA62_C1D6;

    // first padding byte
    localparam logic [BYTE_W-1:0] PAD_MARK = 8'h80;

    // sequencer states
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_PAD   = 5'b00010,
        ST_ROUND = 5'b00100,
        ST_ADD   = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    // rotate left helpers
    function automatic logic [WORD_W-1:0] rotl1(input logic [WORD_W-1:0] x);
        rotl1 = {x[WORD_W-2:0], x[WORD_W-1]};
    endfunction

    function automatic logic [WORD_W-1:0] rotl5(input logic [WORD_W-1:0] x);
        rotl5 = {x[WORD_W-6:0], x[WORD_W-1:WORD_W-5]};
    endfunction

    function automatic logic [WORD_W-1:0] rotl30(input logic [WORD_W-1:0] x);
        rotl30 = {x[1:0], x[WORD_W-1:2]};
    endfunction

endpackage

// ===== rtl/sha1_message_hash_top.sv =====
// sha1_message_hash_top: streaming sha-1 engine, one byte per input item
// depends on sha1mh_pkg
`timescale 1ns / 1ps

// Usage
// The input channel (s_axis_*) carries one item per handshake: tuser holds the
// action (absorb a byte, absorb a byte and finish, finish without a byte, or
// an unused code that is ignored) and tdata holds the byte.
// The output channel (m_axis_*) carries the 160-bit digest, word 0 in the
// lowest 32 bits, once per finished message.
// Each absorbed byte is shifted into the block buffer. The byte that fills a 64-byte
// block starts a compression: the 80 rounds run one per cycle through a single
// round unit fed by a 512-bit schedule shift register, then an add state adds
// the working words to the chaining words.
// A finish pushes the padding bytes through the same buffer one per cycle,
// runs one or two compressions and then loads the digest into the output
// register once that register is free.
// s_axis_tready is high only while the sequencer is idle.
// The digest waits in its own register; the engine keeps taking bytes while
// it waits and only stalls at the end of the next message until the receiver
// has taken it.
// Reset loads the initial vector, clears the bit count and empties the
// output register; the block buffer holds no meaningful data until written.
module sha1_message_hash_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // data_byte [7:0]
    input  logic [sha1mh_pkg::BYTE_W-1:0]      s_axis_tdata,
    // action [1:0]
    input  logic [sha1mh_pkg::ACTION_W-1:0]    s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // digest_word0 [31:0], digest_word1 [63:32], digest_word2 [95:64],
    // digest_word3 [127:96], digest_word4 [159:128]
    output logic [sha1mh_pkg::DIGEST_W-1:0]    m_axis_tdata
);

    localparam int WW = sha1mh_pkg::WORD_W;

    sha1mh_pkg::state_t state_reg, state_next;

    logic [WW-1:0] h0_reg, h1_reg, h2_reg, h3_reg, h4_reg;
    logic [WW-1:0] h0_next, h1_next, h2_next, h3_next, h4_next;
    logic [WW-1:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [WW-1:0] a_next, b_next, c_next, d_next, e_next;
    logic [sha1mh_pkg::BLOCK_W-1:0] blk_reg, blk_next;
    logic [sha1mh_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [sha1mh_pkg::FILL_W-1:0]  fill_reg, fill_next;
    logic [sha1mh_pkg::ROUND_W-1:0] round_reg, round_next;
    logic fin_reg, fin_next;
    logic mark_reg, mark_next;
    logic len_ok_reg, len_ok_next;
    logic out_valid_reg, out_valid_next;
    logic [sha1mh_pkg::DIGEST_W-1:0] out_data_reg, out_data_next;

    logic                          accept;
    sha1mh_pkg::action_t           act;
    logic                          push;
    logic [sha1mh_pkg::BYTE_W-1:0] push_byte;
    logic [sha1mh_pkg::COUNT_W-1:0] len_sh;
    logic [WW-1:0] w_cur, w_new, f_val, k_val, t_val;
    logic out_free;

    assign s_axis_tready = (state_reg == sha1mh_pkg::ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign act           = sha1mh_pkg::action_t'(s_axis_tuser);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign out_free      = !out_valid_reg || m_axis_tready;

    // length byte for the current fill position within the last eight
    assign len_sh = count_reg << {fill_reg[2:0], 3'b000};

    // schedule window: top word is w[r], new word w[r+16] enters at the bottom
    assign w_cur = blk_reg[511:480];
    assign w_new = sha1mh_pkg::rotl1(blk_reg[95:64] ^ blk_reg[255:224]
                                     ^ blk_reg[447:416] ^ blk_reg[511:480]);

    // round function and constant
    always_comb
    begin
        if (round_reg < 7'd20)
        begin
            f_val = d_reg ^ (b_reg & (c_reg ^ d_reg));
            k_val = sha1mh_pkg::K0;
        end
        else if (round_reg < 7'd40)
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = sha1mh_pkg::K1;
        end
        else if (round_reg < 7'd60)
        begin
            f_val = (b_reg & c_reg) | (d_reg & (b_reg | c_reg));
            k_val = sha1mh_pkg::K2;
        end
        else
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = sha1mh_pkg::K3;
        end
    end

    assign t_val = sha1mh_pkg::rotl5(a_reg) + f_val + e_reg + k_val + w_cur;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        h0_next        = h0_reg;
        h1_next        = h1_reg;
        h2_next        = h2_reg;
        h3_next        = h3_reg;
        h4_next        = h4_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        d_next         = d_reg;
        e_next         = e_reg;
        blk_next       = blk_reg;
        count_next     = count_reg;
        fill_next      = fill_reg;
        round_next     = round_reg;
        fin_next       = fin_reg;
        mark_next      = mark_reg;
        len_ok_next    = len_ok_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        push           = 1'b0;
        push_byte      = s_axis_tdata;

        // receiver takes the digest
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            sha1mh_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (act)
                        sha1mh_pkg::ACT_ABSORB,
                        sha1mh_pkg::ACT_ABSORB_END:
                        begin
                            push       = 1'b1;
                            count_next = count_reg + 64'd8;
                            if (act == sha1mh_pkg::ACT_ABSORB_END)
                            begin
                                fin_next    = 1'b1;
                                mark_next   = 1'b1;
                                len_ok_next = 1'b0;
                                state_next  = sha1mh_pkg::ST_PAD;
                            end
                        end
                        sha1mh_pkg::ACT_END:
                        begin
                            fin_next    = 1'b1;
                            mark_next   = 1'b1;
                            len_ok_next = 1'b0;
                            state_next  = sha1mh_pkg::ST_PAD;
                        end
                        default:
                        begin
                            // unused code: nothing changes
                        end
                    endcase
                end
            end
            sha1mh_pkg::ST_PAD:
            begin
                push = 1'b1;
                if (mark_reg)
                begin
                    push_byte = sha1mh_pkg::PAD_MARK;
                    mark_next = 1'b0;
                    if (fill_reg < 6'd56)
                    begin
                        len_ok_next = 1'b1;
                    end
                end
                else if (len_ok_reg && (fill_reg >= 6'd56))
                begin
                    push_byte = len_sh[63:56];
                end
                else
                begin
                    push_byte = '0;
                end
            end
            sha1mh_pkg::ST_ROUND:
            begin
                blk_next   = {blk_reg[479:0], w_new};
                a_next     = t_val;
                b_next     = a_reg;
                c_next     = sha1mh_pkg::rotl30(b_reg);
                d_next     = c_reg;
                e_next     = d_reg;
                round_next = round_reg + 7'd1;
                if (round_reg == 7'(sha1mh_pkg::LAST_ROUND))
                begin
                    state_next = sha1mh_pkg::ST_ADD;
                end
            end
            sha1mh_pkg::ST_ADD:
            begin
                h0_next = h0_reg + a_reg;
                h1_next = h1_reg + b_reg;
                h2_next = h2_reg + c_reg;
                h3_next = h3_reg + d_reg;
                h4_next = h4_reg + e_reg;
                if (!fin_reg)
                begin
                    state_next = sha1mh_pkg::ST_IDLE;
                end
                else if (len_ok_reg)
                begin
                    state_next = sha1mh_pkg::ST_DONE;
                end
                else
                begin
                    // marker already in the previous block: length goes in the next
                    if (!mark_reg)
                    begin
                        len_ok_next = 1'b1;
                    end
                    state_next = sha1mh_pkg::ST_PAD;
                end
            end
            sha1mh_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {h4_reg, h3_reg, h2_reg, h1_reg, h0_reg};
                    h0_next        = sha1mh_pkg::IV0;
                    h1_next        = sha1mh_pkg::IV1;
                    h2_next        = sha1mh_pkg::IV2;
                    h3_next        = sha1mh_pkg::IV3;
                    h4_next        = sha1mh_pkg::IV4;
                    count_next     = '0;
                    fin_next       = 1'b0;
                    len_ok_next    = 1'b0;
                    state_next     = sha1mh_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sha1mh_pkg::ST_IDLE;
            end
        endcase

        // byte into the block buffer; a full block starts the rounds
        if (push)
        begin
            blk_next  = {blk_reg[503:0], push_byte};
            fill_next = fill_reg + 6'd1;
            if (fill_reg == 6'd63)
            begin
                state_next = sha1mh_pkg::ST_ROUND;
                round_next = '0;
                a_next     = h0_reg;
                b_next     = h1_reg;
                c_next     = h2_reg;
                d_next     = h3_reg;
                e_next     = h4_reg;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sha1mh_pkg::ST_IDLE;
            h0_reg        <= sha1mh_pkg::IV0;
            h1_reg        <= sha1mh_pkg::IV1;
            h2_reg        <= sha1mh_pkg::IV2;
            h3_reg        <= sha1mh_pkg::IV3;
            h4_reg        <= sha1mh_pkg::IV4;
            count_reg     <= '0;
            fill_reg      <= '0;
            round_reg     <= '0;
            fin_reg       <= 1'b0;
            mark_reg      <= 1'b0;
            len_ok_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            h0_reg        <= h0_next;
            h1_reg        <= h1_next;
            h2_reg        <= h2_next;
            h3_reg        <= h3_next;
            h4_reg        <= h4_next;
            count_reg     <= count_next;
            fill_reg      <= fill_next;
            round_reg     <= round_next;
            fin_reg       <= fin_next;
            mark_reg      <= mark_next;
            len_ok_reg    <= len_ok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        a_reg        <= a_next;
        b_reg        <= b_next;
        c_reg        <= c_next;
        d_reg        <= d_next;
        e_reg        <= e_next;
        blk_reg      <= blk_next;
        out_data_reg <= out_data_next;
    end

endmodule

// ===== rtl/sha1mh_port_check.sv =====
// sha1mh_port_check: assertions on the ports of sha1_message_hash_top
// depends on sha1mh_pkg; bound to the top level at the end of this file
`timescale 1ns / 1ps

module sha1mh_port_check (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_axis_tvalid,
    input logic                               s_axis_tready,
    input logic [sha1mh_pkg::BYTE_W-1:0]      s_axis_tdata,
    input logic [sha1mh_pkg::ACTION_W-1:0]    s_axis_tuser,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [sha1mh_pkg::DIGEST_W-1:0]    m_axis_tdata
);

    logic s_acc;
    assign s_acc = s_axis_tvalid && s_axis_tready;

    // a waiting digest holds still
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("digest changed while stalled");

    // a finish without a byte always starts padding
    a_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc && (s_axis_tuser == sha1mh_pkg::ACT_END) |=> !s_axis_tready)
        else $error("engine ready right after a finish");

    // a byte with finish always starts padding or rounds
    a_abs_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc && (s_axis_tuser == sha1mh_pkg::ACT_ABSORB_END) |=> !s_axis_tready)
        else $error("engine ready right after a finishing byte");

    // a new digest only comes out of a busy engine
    a_digest_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("digest appeared while idle");

    // an unused code never changes readiness
    a_none_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc && (s_axis_tuser == sha1mh_pkg::ACT_NONE) |=> s_axis_tready)
        else $error("unused action code made the engine busy");

endmodule

bind sha1_message_hash_top sha1mh_port_check u_sha1mh_port_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/sv/tb.sv =====
// tb: self-checking bench for sha1_message_hash_top, byte stream in, digest out
// depends on sha1mh_pkg and the rtl of sha1_message_hash_top; holds its own sha-1 predictor
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 300;
    localparam int RANDOM_ITEMS  = 1050;
    localparam int REPORT_LIMIT  = 10;
    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [31:0] SHA1_IV [5] = '{32'h67452301, 32'hEFCDAB89, 32'h98BADCFE,
                                            32'h10325476, 32'hC3D2E1F0};
    localparam logic [31:0] ROUND_K [4] = '{32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC,
                                            32'hCA62C1D6};

    // handshake pressure applied while an item of each group is in flight
    typedef enum logic [1:0] {
        PH_STEADY      = 2'd0,
        PH_SEND_GAPS   = 2'd1,
        PH_SINK_STALLS = 2'd2,
        PH_LIGHT_BOTH  = 2'd3
    } pressure_t;

    typedef struct packed {
        sha1mh_pkg::action_t act;
        logic [7:0]          data;
        pressure_t           phase;
    } byte_item_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [sha1mh_pkg::BYTE_W-1:0]   s_axis_tdata = '0;
    logic [sha1mh_pkg::ACTION_W-1:0] s_axis_tuser = sha1mh_pkg::ACT_NONE;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [sha1mh_pkg::DIGEST_W-1:0] m_axis_tdata;

    // stimulus waiting for the driver and digests waiting for the monitor
    byte_item_t                      pending_items[$];
    logic [sha1mh_pkg::DIGEST_W-1:0] expected_digests[$];
    byte_item_t                      next_item;
    pressure_t                       cur_phase = PH_STEADY;

    // predictor state
    logic [31:0] chain_h [5];
    logic [7:0]  msg_block [64];
    logic [63:0] msg_bits;

    int cycle_count = 0;
    int err_count = 0;
    int bytes_hashed = 0;
    int items_hashed = 0;
    int items_ignored = 0;
    int digests_checked = 0;
    int msgs_sent = 0;

    sha1_message_hash_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock, 10 ns period
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [31:0] rol32(input logic [31:0] x, input int n);
        rol32 = (x << n) | (x >> (32 - n));
    endfunction

    function automatic bit chance(input int pct);
        chance = ($urandom_range(99) < pct);
    endfunction

    function automatic int send_gap_pct(input pressure_t ph);
        send_gap_pct = (ph == PH_SEND_GAPS) ? 45 : (ph == PH_LIGHT_BOTH) ? 6 : 0;
    endfunction

    function automatic int sink_stall_pct(input pressure_t ph);
        sink_stall_pct = (ph == PH_SINK_STALLS) ? 45 : (ph == PH_LIGHT_BOTH) ? 6 : 0;
    endfunction

    // 80-round compression of the gathered block into the chaining words
    task automatic sha1_compress();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int r = 0; r < 16; r++)
        begin
            w[r] = {msg_block[4*r], msg_block[4*r+1], msg_block[4*r+2], msg_block[4*r+3]};
        end
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        e = chain_h[4];
        for (int r = 0; r < 80; r++)
        begin
            // rolling schedule, sixteen words deep
            if (r >= 16)
            begin
                w[r%16] = rol32(w[(r-3)%16] ^ w[(r-8)%16] ^ w[(r-14)%16] ^ w[r%16], 1);
            end
            if (r < 20)
            begin
                f = d ^ (b & (c ^ d));
                k = ROUND_K[0];
            end
            else if (r < 40)
            begin
                f = b ^ c ^ d;
                k = ROUND_K[1];
            end
            else if (r < 60)
            begin
                f = (b & c) | (d & (b | c));
                k = ROUND_K[2];
            end
            else
            begin
                f = b ^ c ^ d;
                k = ROUND_K[3];
            end
            t = rol32(a, 5) + f + e + k + w[r%16];
            e = d;
            d = c;
            c = rol32(b, 30);
            b = a;
            a = t;
        end
        chain_h[0] += a;
        chain_h[1] += b;
        chain_h[2] += c;
        chain_h[3] += d;
        chain_h[4] += e;
    endtask

    task automatic sha1_restart();
        for (int i = 0; i < 5; i++)
        begin
            chain_h[i] = SHA1_IV[i];
        end
        msg_bits = '0;
    endtask

    task automatic sha1_absorb(input logic [7:0] b);
        int pos;
        pos = msg_bits[8:3];
        msg_block[pos] = b;
        msg_bits += 64'd8;
        if (pos == 63)
        begin
            sha1_compress();
        end
    endtask

    // one accepted item: absorb, and on a finish pad and queue the digest
    task automatic sha1_take_item(input sha1mh_pkg::action_t act, input logic [7:0] b);
        logic [63:0] length;
        int pos;
        if (act == sha1mh_pkg::ACT_NONE)
        begin
            items_ignored++;
            return;
        end
        items_hashed++;
        if (act != sha1mh_pkg::ACT_END)
        begin
            sha1_absorb(b);
            bytes_hashed++;
        end
        if (act == sha1mh_pkg::ACT_ABSORB)
        begin
            return;
        end
        length = msg_bits;
        pos = msg_bits[8:3];
        msg_block[pos] = PAD_BYTE;
        pos++;
        // no room left for the length: pad out and compress an extra block
        if (pos > 56)
        begin
            while (pos < 64)
            begin
                msg_block[pos] = 8'h00;
                pos++;
            end
            sha1_compress();
            pos = 0;
        end
        while (pos < 56)
        begin
            msg_block[pos] = 8'h00;
            pos++;
        end
        for (int i = 0; i < 8; i++)
        begin
            msg_block[56+i] = length[63-8*i -: 8];
        end
        sha1_compress();
        expected_digests.push_back({chain_h[4], chain_h[3], chain_h[2], chain_h[1], chain_h[0]});
        sha1_restart();
    endtask

    // compare one received digest with the oldest expectation, word by word
    task automatic check_digest(input logic [sha1mh_pkg::DIGEST_W-1:0] got);
        logic [sha1mh_pkg::DIGEST_W-1:0] want;
        if (expected_digests.size() == 0)
        begin
            err_count++;
            if (err_count <= REPORT_LIMIT)
            begin
                $display("ERROR: digest %h arrived with no message finished", got);
            end
            return;
        end
        want = expected_digests.pop_front();
        digests_checked++;
        for (int i = 0; i < 5; i++)
        begin
            if (got[32*i +: 32] !== want[32*i +: 32])
            begin
                err_count++;
                if (err_count <= REPORT_LIMIT)
                begin
                    $display("ERROR: digest %0d word %0d expected %h got %h",
                             digests_checked, i, want[32*i +: 32], got[32*i +: 32]);
                end
            end
        end
    endtask

    task automatic push_item(input sha1mh_pkg::action_t act, input logic [7:0] data,
                             input pressure_t ph);
        byte_item_t it;
        it.act = act;
        it.data = data;
        it.phase = ph;
        pending_items.push_back(it);
    endtask

    // lengths around the padding boundaries get extra weight
    function automatic int pick_length();
        int r;
        int edges [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
        r = $urandom_range(99);
        if (r < 45)
        begin
            pick_length = $urandom_range(20);
        end
        else if (r < 80)
        begin
            pick_length = edges[$urandom_range(9)];
        end
        else
        begin
            pick_length = $urandom_range(140, 21);
        end
    endfunction

    // driver: a new item goes out once the current one has been taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= sha1mh_pkg::ACT_NONE;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (s_axis_tvalid)
            begin
                sha1_take_item(sha1mh_pkg::action_t'(s_axis_tuser), s_axis_tdata);
            end
            if (pending_items.size() != 0 && !chance(send_gap_pct(pending_items[0].phase)))
            begin
                next_item = pending_items.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= next_item.data;
                s_axis_tuser  <= next_item.act;
                cur_phase     <= next_item.phase;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor: check each taken digest, stall the output side at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                check_digest(m_axis_tdata);
            end
            m_axis_tready <= !chance(sink_stall_pct(cur_phase));
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("ERROR: timeout after %0d cycles, %0d digests still expected",
                     cycle_count, expected_digests.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // stimulus, reset and end of run
    initial
    begin
        int len;
        int rand_items;
        int msg_idx;
        pressure_t ph;
        bit end_with_byte;

        sha1_restart();
        for (int i = 0; i < 64; i++)
        begin
            msg_block[i] = 8'h00;
        end

        // directed: empty message, "abc", ignored codes, byte extremes
        push_item(sha1mh_pkg::ACT_END, 8'h00, PH_STEADY);
        push_item(sha1mh_pkg::ACT_ABSORB, 8'h61, PH_STEADY);
        push_item(sha1mh_pkg::ACT_ABSORB, 8'h62, PH_STEADY);
        push_item(sha1mh_pkg::ACT_ABSORB_END, 8'h63, PH_STEADY);
        push_item(sha1mh_pkg::ACT_ABSORB, 8'h00, PH_STEADY);
        push_item(sha1mh_pkg::ACT_NONE, 8'h5A, PH_STEADY);
        push_item(sha1mh_pkg::ACT_ABSORB_END, 8'hFF, PH_STEADY);
        push_item(sha1mh_pkg::ACT_ABSORB_END, 8'hFF, PH_STEADY);
        push_item(sha1mh_pkg::ACT_ABSORB, 8'h80, PH_STEADY);
        push_item(sha1mh_pkg::ACT_ABSORB, 8'h7F, PH_STEADY);
        push_item(sha1mh_pkg::ACT_END, 8'hA5, PH_STEADY);
        push_item(sha1mh_pkg::ACT_NONE, 8'hFF, PH_STEADY);
        push_item(sha1mh_pkg::ACT_END, 8'hFF, PH_STEADY);
        push_item(sha1mh_pkg::ACT_END, 8'h00, PH_STEADY);
        msgs_sent = 7;

        // random messages, pressure group changes every four messages
        rand_items = 0;
        msg_idx = 0;
        while (rand_items < RANDOM_ITEMS)
        begin
            ph = pressure_t'((msg_idx / 4) % 4);
            len = pick_length();
            end_with_byte = (len != 0) && ($urandom_range(1) == 1);
            for (int i = 0; i < len; i++)
            begin
                if (chance(4))
                begin
                    push_item(sha1mh_pkg::ACT_NONE, 8'($urandom), ph);
                end
                push_item((end_with_byte && i == len - 1) ? sha1mh_pkg::ACT_ABSORB_END
                                                          : sha1mh_pkg::ACT_ABSORB,
                          8'($urandom), ph);
                rand_items++;
            end
            if (!end_with_byte)
            begin
                push_item(sha1mh_pkg::ACT_END, 8'($urandom), ph);
                rand_items++;
            end
            msg_idx++;
        end
        msgs_sent += msg_idx;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() != 0 || s_axis_tvalid || expected_digests.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Hashed %0d bytes in %0d items over %0d messages, %0d items ignored",
                 bytes_hashed, items_hashed, msgs_sent, items_ignored);
        $display("Checked %0d digests under four stall patterns, %0d mismatches",
                 digests_checked, err_count);
        if (err_count == 0 && expected_digests.size() == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
